// ===== rtl/leb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and constants of the LEB128 stream decoder.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int VALUE_BITS = 64;
  localparam int GROUP_BITS = 7;
  localparam int SHIFT_W    = 7;
  localparam int SHIFT_MAX  = 70;   // ten groups gathered
  localparam int CONT_BIT   = 7;
  localparam int SIGN_BIT   = 6;

  // Queue depths, powers of two so the pointers wrap by themselves
  localparam int TQ_DEPTH = 4;
  localparam int RQ_DEPTH = 2;

  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_SIGNED_MODE = 2'd0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_LONG  = 2'd2
  } status_t;

  // Classified input word
  typedef struct packed {
    logic [GROUP_BITS-1:0] group;
    logic                  cont;
    logic                  last;
  } token_t;

  // Front to back channel
  typedef struct packed {
    logic   valid;
    token_t tok;
  } tok_chan_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    status_t               status;
  } result_t;

endpackage

// ===== rtl/leb128_stream_decoder.sv =====
`timescale 1ns / 1ps
// Path: a terminating word is written into the token queue, then taken by the
//   back end into the result queue, where it shows on value/status for a pop.
// Throughput: one word per cycle, set by the shift-or of the
//   group accumulator; stalls only when the result side stops popping.
// Reset: synchronous; clears both queues, the accumulator, the group
//   position and signed_mode (unsigned decoding).
// ----------------------------------------------------------------------------
// leb128_stream_decoder
// LEB128 varint decoder over a byte stream, unsigned or signed, with
// truncated and too-long status.
// ----------------------------------------------------------------------------
module leb128_stream_decoder
  import leb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  // input word side
  input  logic [7:0]            data_byte,
  input  logic                  end_of_buffer,
  input  logic                  push,
  output logic                  full,
  // result side
  output logic [VALUE_BITS-1:0] value,
  output logic [1:0]            status,
  output logic                  empty,
  input  logic                  pop
);

  logic      signed_mode;
  logic      cfg_write;
  tok_chan_t chan;
  logic      take;

  // Register file: a single mode bit. Writes complete in the access phase;
  // the port never inserts wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (cfg_write && (paddr == REG_SIGNED_MODE)) begin
      signed_mode <= pwdata[0];
    end
  end

  // Reads of unknown addresses return zero.
  always_comb begin
    prdata = '0;
    if (paddr == REG_SIGNED_MODE) begin
      prdata = {{(PDATA_W-1){1'b0}}, signed_mode};
    end
  end

  // Front end: take a word whenever the token queue has room.
  leb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .push          (push),
    .full          (full),
    .chan          (chan),
    .take          (take)
  );

  // Back end: advance the accumulator one group per cycle while the result queue
  // has room, and queue each finished value; mode is sampled at the terminating word.
  leb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .signed_mode (signed_mode),
    .chan        (chan),
    .take        (take),
    .empty       (empty),
    .pop         (pop),
    .value       (value),
    .status      (status)
  );

endmodule

// ===== rtl/leb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_front
// Accepts input words, splits each into group, continuation and end mark,
// and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module leb_front
  import leb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  input  logic       push,
  output logic       full,
  output tok_chan_t  chan,
  input  logic       take
);

  localparam int PTR_W = $clog2(TQ_DEPTH);
  localparam int CNT_W = $clog2(TQ_DEPTH + 1);

  token_t             q [TQ_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               accept;
  logic               drain;
  token_t             tok_in;

  assign full   = (count == CNT_W'(TQ_DEPTH));
  assign accept = push && !full;
  assign drain  = take && chan.valid;

  always_comb begin
    tok_in.group = data_byte[GROUP_BITS-1:0];
    tok_in.cont  = data_byte[CONT_BIT];
    tok_in.last  = end_of_buffer;
  end

  assign chan.valid = (count != '0);
  assign chan.tok   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + 1'b1;
      if (drain)  rd_ptr <= rd_ptr + 1'b1;
      case ({accept, drain})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TQ_DEPTH))
    else $error("token queue overfilled");

  a_drain_only: assert property (@(posedge clk) disable iff (rst)
    (drain && !accept) |=> (count == $past(count) - 1'b1))
    else $error("token queue count lost a drain");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    PTR_W'(count) == PTR_W'(wr_ptr - rd_ptr))
    else $error("token queue pointers disagree with count");
`endif

endmodule

// ===== rtl/leb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_back
// Gathers groups into the value, finishes it with sign extension or an
// error status, and queues finished results for the consumer.
// ----------------------------------------------------------------------------
module leb_back
  import leb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  signed_mode,
  input  tok_chan_t             chan,
  output logic                  take,
  output logic                  empty,
  input  logic                  pop,
  output logic [VALUE_BITS-1:0] value,
  output logic [1:0]            status
);

  localparam int PTR_W = $clog2(RQ_DEPTH);
  localparam int CNT_W = $clog2(RQ_DEPTH + 1);

  logic [VALUE_BITS-1:0] acc;
  logic [SHIFT_W-1:0]    shift;
  logic [VALUE_BITS-1:0] acc_next;
  logic [SHIFT_W-1:0]    shift_next;
  logic [VALUE_BITS-1:0] sext;
  logic                  emit;
  result_t               res;

  result_t               rq [RQ_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  rq_full;
  logic                  rq_pop;
  logic                  rq_push;

  assign rq_full = (count == CNT_W'(RQ_DEPTH));
  assign take    = chan.valid && !rq_full;
  assign rq_push = take && emit;
  assign rq_pop  = pop && !empty;

  always_comb begin
    acc_next   = acc | ({{(VALUE_BITS-GROUP_BITS){1'b0}}, chan.tok.group} << shift[5:0]);
    shift_next = shift + SHIFT_W'(GROUP_BITS);
    sext       = {VALUE_BITS{1'b1}} << shift_next[5:0];
    emit       = 1'b0;
    res.value  = '0;
    res.status = ST_OK;
    if (shift >= SHIFT_W'(SHIFT_MAX)) begin
      // eleventh group: drop the word whatever it holds
      emit       = 1'b1;
      res.status = ST_LONG;
    end else if (!chan.tok.cont) begin
      emit      = 1'b1;
      res.value = acc_next;
      if (signed_mode && (shift_next < SHIFT_W'(VALUE_BITS)) &&
          chan.tok.group[SIGN_BIT]) begin
        res.value = acc_next | sext;
      end
    end else if (chan.tok.last) begin
      emit       = 1'b1;
      res.status = ST_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      shift <= '0;
    end else if (take) begin
      if (emit) begin
        acc   <= '0;
        shift <= '0;
      end else begin
        acc   <= acc_next;
        shift <= shift_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (rq_push) wr_ptr <= wr_ptr + 1'b1;
      if (rq_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({rq_push, rq_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign empty  = (count == '0);
  assign value  = rq[rd_ptr].value;
  assign status = rq[rd_ptr].status;

`ifndef ASSERT_OFF
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (take && emit) |=> (shift == '0 && acc == '0))
    else $error("state not cleared after a result");

  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    shift <= SHIFT_W'(SHIFT_MAX))
    else $error("group position past ten groups");

  a_no_take_full: assert property (@(posedge clk) disable iff (rst)
    rq_full |-> !take)
    else $error("token taken with result queue full");
`endif

endmodule
